FILE: sv/cts_pkg.sv
`default_nettype none

package cts_pkg;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_POST  = 2'd1,
        OP_TIMED = 2'd2,
        OP_STOP  = 2'd3
    } op_t;

    localparam logic [1:0] ST_WORKING = 2'd0;
    localparam logic [1:0] ST_IDLE    = 2'd1;
    localparam logic [1:0] ST_STOPPED = 2'd2;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_OVERFLOW = 2'd1;
    localparam logic [1:0] ERR_TIMERS   = 2'd2;

    localparam int ID_W  = 8;
    localparam int DLY_W = 16;
    localparam int MS_W  = 32;

    typedef struct packed {
        logic load;
        logic exec;
        logic scan;
        logic deq;
        logic rd;
        logic out_load;
    } cts_cmd_t;

    typedef struct packed {
        op_t  op;
        logic stopped;
        logic slot_free;
        logic scan_last;
        logic q_empty;
    } cts_stat_t;

endpackage

`default_nettype wire

FILE: sv/cts_ctrl.sv
`default_nettype none

module cts_ctrl
    import cts_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    output logic      out_valid,
    input  logic      out_stall,
    input  cts_stat_t stat,
    output cts_cmd_t  cmd
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_EXEC = 6'b000010,
        S_SCAN = 6'b000100,
        S_DEQ  = 6'b001000,
        S_READ = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (stat.op == OP_TIMED || (stat.op == OP_TICK && !stat.stopped))
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.op == OP_TIMED && stat.slot_free)
                begin
                    state_next = S_DONE;
                end
                else if (stat.scan_last)
                begin
                    state_next = (stat.op == OP_TICK) ? S_DEQ : S_DONE;
                end
            end
            S_DEQ:
            begin
                cmd.deq    = 1'b1;
                state_next = stat.q_empty ? S_DONE : S_READ;
            end
            S_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

FILE: sv/cts_datapath.sv
`default_nettype none

module cts_datapath
    import cts_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int TIMER_SLOTS = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cts_cmd_t         cmd,
    output cts_stat_t        stat,
    input  logic [1:0]       operation,
    input  logic [ID_W-1:0]  task_id,
    input  logic [DLY_W-1:0] delay_ms,
    input  logic [MS_W-1:0]  now_ms,
    output logic             dispatched,
    output logic [ID_W-1:0]  run_task,
    output logic             idle_now,
    output logic [1:0]       sched_status,
    output logic [1:0]       error_code,
    output logic [MS_W-1:0]  busy_time
);

    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int TW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

    logic [ID_W:0]      queue_mem [QUEUE_DEPTH];
    logic [ID_W:0]      q_rdata_reg;
    logic [MS_W-1:0]    deadline_mem [TIMER_SLOTS];
    logic [ID_W-1:0]    tmr_task_mem [TIMER_SLOTS];

    logic [QW-1:0]      head_reg;
    logic [QW-1:0]      tail_reg;
    logic [TIMER_SLOTS-1:0] tvalid_reg;
    logic [TW-1:0]      idx_reg;
    logic [MS_W-1:0]    last_idle_reg;
    logic               stopped_reg;

    op_t                op_reg;
    logic [ID_W-1:0]    id_reg;
    logic [DLY_W-1:0]   delay_reg;
    logic [MS_W-1:0]    now_reg;
    logic               disp_reg;
    logic [ID_W-1:0]    task_reg;
    logic               idle_reg;
    logic [1:0]         err_reg;

    logic               dispatched_reg;
    logic [ID_W-1:0]    run_task_reg;
    logic               idle_now_reg;
    logic [1:0]         sched_status_reg;
    logic [1:0]         error_code_reg;
    logic [MS_W-1:0]    busy_time_reg;

    logic [QW-1:0]      head_inc;
    logic [QW-1:0]      tail_inc;
    logic               q_full;
    logic               timer_hit;
    logic               slot_free;
    logic               scan_last;
    logic               enq_req;
    logic [ID_W:0]      enq_entry;
    logic               q_we;
    logic               q_re;
    logic               timed_miss;
    logic [1:0]         status_res;

    always_comb
    begin
        head_inc  = (head_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
        tail_inc  = (tail_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
        q_full    = (tail_inc == head_reg);
        timer_hit = tvalid_reg[idx_reg] && (now_reg >= deadline_mem[idx_reg]);
        slot_free = !tvalid_reg[idx_reg];
        scan_last = (idx_reg == TW'(TIMER_SLOTS - 1));
        enq_req   = (cmd.exec && (op_reg == OP_POST || op_reg == OP_STOP))
                  || (cmd.scan && op_reg == OP_TICK && timer_hit);
        if (cmd.scan)
        begin
            enq_entry = {1'b0, tmr_task_mem[idx_reg]};
        end
        else
        begin
            enq_entry = {(op_reg == OP_STOP), id_reg};
        end
        q_we       = enq_req && !q_full;
        q_re       = cmd.deq && (head_reg != tail_reg);
        timed_miss = cmd.scan && op_reg == OP_TIMED && scan_last && !slot_free;
        if (op_reg == OP_STOP || stopped_reg)
        begin
            status_res = ST_STOPPED;
        end
        else if (idle_reg)
        begin
            status_res = ST_IDLE;
        end
        else
        begin
            status_res = ST_WORKING;
        end
    end

    always_comb
    begin
        stat.op        = op_reg;
        stat.stopped   = stopped_reg;
        stat.slot_free = slot_free;
        stat.scan_last = scan_last;
        stat.q_empty   = (head_reg == tail_reg);
    end

    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            queue_mem[tail_inc] <= enq_entry;
        end
        if (q_re)
        begin
            q_rdata_reg <= queue_mem[head_inc];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            tvalid_reg    <= '0;
            idx_reg       <= '0;
            last_idle_reg <= '0;
            stopped_reg   <= 1'b0;
        end
        else
        begin
            if (q_we)
            begin
                tail_reg <= tail_inc;
            end
            if (cmd.load)
            begin
                idx_reg <= '0;
            end
            else if (cmd.scan && !scan_last)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.scan && op_reg == OP_TICK && timer_hit)
            begin
                tvalid_reg[idx_reg] <= 1'b0;
            end
            else if (cmd.scan && op_reg == OP_TIMED && slot_free)
            begin
                tvalid_reg[idx_reg] <= 1'b1;
            end
            if (cmd.deq)
            begin
                if (head_reg == tail_reg)
                begin
                    last_idle_reg <= now_reg;
                end
                else
                begin
                    head_reg <= head_inc;
                end
            end
            if (cmd.rd && q_rdata_reg[ID_W])
            begin
                stopped_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan && op_reg == OP_TIMED && slot_free)
        begin
            deadline_mem[idx_reg] <= now_reg + MS_W'(delay_reg);
            tmr_task_mem[idx_reg] <= id_reg;
        end
        if (cmd.load)
        begin
            op_reg    <= op_t'(operation);
            id_reg    <= task_id;
            delay_reg <= delay_ms;
            now_reg   <= now_ms;
            disp_reg  <= 1'b0;
            task_reg  <= '0;
            idle_reg  <= 1'b0;
            err_reg   <= ERR_NONE;
        end
        else
        begin
            if (enq_req && q_full)
            begin
                err_reg <= ERR_OVERFLOW;
            end
            else if (timed_miss)
            begin
                err_reg <= ERR_TIMERS;
            end
            if (cmd.deq && head_reg == tail_reg)
            begin
                idle_reg <= 1'b1;
            end
            if (cmd.rd && !q_rdata_reg[ID_W])
            begin
                disp_reg <= 1'b1;
                task_reg <= q_rdata_reg[ID_W-1:0];
            end
        end
        if (cmd.out_load)
        begin
            dispatched_reg   <= disp_reg;
            run_task_reg     <= task_reg;
            idle_now_reg     <= idle_reg;
            sched_status_reg <= status_res;
            error_code_reg   <= err_reg;
            busy_time_reg    <= now_reg - last_idle_reg;
        end
    end

    assign dispatched   = dispatched_reg;
    assign run_task     = run_task_reg;
    assign idle_now     = idle_now_reg;
    assign sched_status = sched_status_reg;
    assign error_code   = error_code_reg;
    assign busy_time    = busy_time_reg;

endmodule

`default_nettype wire

FILE: sv/cooperative_task_scheduler_unit.sv
`default_nettype none

// Cooperative run-queue scheduler with millisecond timers. Each request on the
// input channel (tick, post, timed post or stop) yields exactly one result on
// the output channel. A post or stop goes from acceptance through the execute
// and done states to the output register. A timed post and a tick that is not
// stopped also pass the timer scan, which examines one timer slot per cycle,
// and a tick goes on through the dequeue state and, when the run queue is not
// empty, the registered read port of the run queue memory. A new request is
// accepted as soon as the previous one has reached the output register, even
// while that result is still stalled.
module cooperative_task_scheduler_unit
    import cts_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int TIMER_SLOTS = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [1:0]       operation,
    input  logic [ID_W-1:0]  task_id,
    input  logic [DLY_W-1:0] delay_ms,
    input  logic [MS_W-1:0]  now_ms,
    output logic             out_valid,
    input  logic             out_stall,
    output logic             dispatched,
    output logic [ID_W-1:0]  run_task,
    output logic             idle_now,
    output logic [1:0]       sched_status,
    output logic [1:0]       error_code,
    output logic [MS_W-1:0]  busy_time
);

    cts_cmd_t  cmd;
    cts_stat_t stat;

    cts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    cts_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TIMER_SLOTS (TIMER_SLOTS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .operation    (operation),
        .task_id      (task_id),
        .delay_ms     (delay_ms),
        .now_ms       (now_ms),
        .dispatched   (dispatched),
        .run_task     (run_task),
        .idle_now     (idle_now),
        .sched_status (sched_status),
        .error_code   (error_code),
        .busy_time    (busy_time)
    );

`ifndef SYNTHESIS
    a_disp_working: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && dispatched |-> !idle_now && sched_status == ST_WORKING)
        else $error("dispatch reported with wrong status");

    a_idle_zero_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && idle_now |-> sched_status == ST_IDLE && busy_time == '0)
        else $error("idle result with nonzero busy time");

    a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        stat.stopped |=> stat.stopped)
        else $error("stopped state cleared without reset");
`endif

endmodule

`default_nettype wire

FILE: sim/tb_cooperative_task_scheduler_unit.sv
`timescale 1ns / 100ps

module tb_cooperative_task_scheduler_unit;
    import cts_pkg::*;

    localparam int QD = 16;
    localparam int TS = 8;
    localparam int LIMIT = 300000;

    typedef struct packed {
        logic        disp;
        logic [7:0]  run_id;
        logic        idle;
        logic [1:0]  status;
        logic [1:0]  err;
        logic [31:0] busy;
    } sched_result_t;

    // Scoreboard with its own copy of the run queue, the timer table and the idle stamp.
    class sched_scoreboard;
        logic [8:0]    ring [QD];
        logic [3:0]    rd_ptr;
        logic [3:0]    wr_ptr;
        logic [31:0]   alarm_at [TS];
        logic [7:0]    alarm_id [TS];
        bit            alarm_armed [TS];
        logic [31:0]   idle_stamp;
        bit            halted;
        sched_result_t due_results [$];
        int            errors;
        int            requests;
        int            results;
        int            dispatches;
        int            idle_ticks;
        int            overflows;
        int            table_full;

        function new();
            rd_ptr = '0;
            wr_ptr = '0;
            idle_stamp = '0;
            halted = 1'b0;
            foreach (alarm_armed[k]) alarm_armed[k] = 1'b0;
            errors = 0;
            requests = 0;
            results = 0;
            dispatches = 0;
            idle_ticks = 0;
            overflows = 0;
            table_full = 0;
        endfunction

        function int fill();
            logic [3:0] n;
            n = wr_ptr - rd_ptr;
            return int'(n);
        endfunction

        function int armed();
            int n;
            n = 0;
            foreach (alarm_armed[k]) n += alarm_armed[k];
            return n;
        endfunction

        function bit push_entry(logic [8:0] entry);
            logic [3:0] nxt;
            nxt = wr_ptr + 4'd1;
            if (nxt == rd_ptr)
                return 1'b0;
            wr_ptr = nxt;
            ring[nxt] = entry;
            return 1'b1;
        endfunction

        function void note_request(op_t op, logic [7:0] id, logic [15:0] dly, logic [31:0] ms);
            sched_result_t r;
            int k;
            r = '0;
            case (op)
                OP_TICK:
                begin
                    if (halted)
                    begin
                        r.status = ST_STOPPED;
                    end
                    else
                    begin
                        for (k = 0; k < TS; k++)
                        begin
                            if (alarm_armed[k] && ms >= alarm_at[k])
                            begin
                                if (!push_entry({1'b0, alarm_id[k]}))
                                    r.err = ERR_OVERFLOW;
                                alarm_armed[k] = 1'b0;
                            end
                        end
                        if (rd_ptr == wr_ptr)
                        begin
                            r.idle = 1'b1;
                            r.status = ST_IDLE;
                            idle_stamp = ms;
                        end
                        else
                        begin
                            rd_ptr = rd_ptr + 4'd1;
                            if (ring[rd_ptr][8])
                            begin
                                halted = 1'b1;
                                r.status = ST_STOPPED;
                            end
                            else
                            begin
                                r.disp = 1'b1;
                                r.run_id = ring[rd_ptr][7:0];
                                r.status = ST_WORKING;
                            end
                        end
                    end
                end
                OP_POST:
                begin
                    if (!push_entry({1'b0, id}))
                        r.err = ERR_OVERFLOW;
                    r.status = halted ? ST_STOPPED : ST_WORKING;
                end
                OP_TIMED:
                begin
                    for (k = 0; k < TS; k++)
                        if (!alarm_armed[k])
                            break;
                    if (k >= TS)
                    begin
                        r.err = ERR_TIMERS;
                    end
                    else
                    begin
                        alarm_armed[k] = 1'b1;
                        alarm_at[k] = ms + 32'(dly);
                        alarm_id[k] = id;
                    end
                    r.status = halted ? ST_STOPPED : ST_WORKING;
                end
                default:
                begin
                    if (!push_entry(9'h100))
                        r.err = ERR_OVERFLOW;
                    r.status = ST_STOPPED;
                end
            endcase
            r.busy = ms - idle_stamp;
            requests++;
            dispatches += r.disp;
            idle_ticks += r.idle;
            overflows += (r.err == ERR_OVERFLOW);
            table_full += (r.err == ERR_TIMERS);
            due_results.push_back(r);
        endfunction

        task report_mismatch(string msg);
            if (errors < 40)
                $display("MISMATCH: %s", msg);
            errors++;
        endtask

        task check_result(sched_result_t got);
            sched_result_t want;
            results++;
            if (due_results.size() == 0)
            begin
                report_mismatch($sformatf("result %0d arrived with none expected", results));
            end
            else
            begin
                want = due_results.pop_front();
                if (got.disp !== want.disp)
                    report_mismatch($sformatf("result %0d dispatched: got %0b, expected %0b",
                                              results, got.disp, want.disp));
                if (got.run_id !== want.run_id)
                    report_mismatch($sformatf("result %0d run_task: got %0h, expected %0h",
                                              results, got.run_id, want.run_id));
                if (got.idle !== want.idle)
                    report_mismatch($sformatf("result %0d idle_now: got %0b, expected %0b",
                                              results, got.idle, want.idle));
                if (got.status !== want.status)
                    report_mismatch($sformatf("result %0d sched_status: got %0d, expected %0d",
                                              results, got.status, want.status));
                if (got.err !== want.err)
                    report_mismatch($sformatf("result %0d error_code: got %0d, expected %0d",
                                              results, got.err, want.err));
                if (got.busy !== want.busy)
                    report_mismatch($sformatf("result %0d busy_time: got %0h, expected %0h",
                                              results, got.busy, want.busy));
            end
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  operation = '0;
    logic [7:0]  task_id = '0;
    logic [15:0] delay_ms = '0;
    logic [31:0] now_ms = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        dispatched;
    logic [7:0]  run_task;
    logic        idle_now;
    logic [1:0]  sched_status;
    logic [1:0]  error_code;
    logic [31:0] busy_time;

    sched_scoreboard sb;
    int          idle_pct = 16;
    int          cycle_count = 0;
    logic [31:0] clock_ms = '0;

    cooperative_task_scheduler_unit #(
        .QUEUE_DEPTH (QD),
        .TIMER_SLOTS (TS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .task_id      (task_id),
        .delay_ms     (delay_ms),
        .now_ms       (now_ms),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .dispatched   (dispatched),
        .run_task     (run_task),
        .idle_now     (idle_now),
        .sched_status (sched_status),
        .error_code   (error_code),
        .busy_time    (busy_time)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && !out_stall)
            sb.check_result({dispatched, run_task, idle_now, sched_status, error_code,
                             busy_time});
    end

    initial
    begin
        while (cycle_count < LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_cooperative_task_scheduler_unit: done, errors");
        $finish;
    end

    task automatic issue_request(op_t op, logic [7:0] id, logic [15:0] dly, logic [31:0] ms);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        task_id <= id;
        delay_ms <= dly;
        now_ms <= ms;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_request(op, id, dly, ms);
    endtask

    task automatic tick_request();
        clock_ms += $urandom_range(0, 25);
        issue_request(OP_TICK, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                      clock_ms);
    endtask

    task automatic fill_to_overflow();
        while (sb.fill() < QD - 1)
            issue_request(OP_POST, 8'($urandom_range(0, 255)),
                          16'($urandom_range(0, 65535)), clock_ms);
        issue_request(OP_POST, 8'($urandom_range(0, 255)),
                      16'($urandom_range(0, 65535)), clock_ms);
        issue_request(OP_STOP, 8'($urandom_range(0, 255)),
                      16'($urandom_range(0, 65535)), clock_ms);
        while (sb.armed() < TS)
            issue_request(OP_TIMED, 8'($urandom_range(0, 255)),
                          16'($urandom_range(0, 3)), clock_ms);
        issue_request(OP_TIMED, 8'($urandom_range(0, 255)),
                      16'($urandom_range(0, 3)), clock_ms);
        clock_ms += 5;
        issue_request(OP_TICK, 8'($urandom_range(0, 255)),
                      16'($urandom_range(0, 65535)), clock_ms);
    endtask

    task automatic noise_request();
        op_t op;
        logic [31:0] ms;
        op = op_t'($urandom_range(0, 2));
        if (sb.fill() == QD - 1 && $urandom_range(0, 2) == 0)
            op = OP_STOP;
        ms = ($urandom_range(0, 1) == 0) ? $urandom() : clock_ms;
        issue_request(op, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)), ms);
    endtask

    initial
    begin
        int n;
        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue_request(OP_TICK, 8'h00, 16'h0000, 32'd0);
        issue_request(OP_POST, 8'h00, 16'hFFFF, 32'd1);
        issue_request(OP_POST, 8'hFF, 16'h0000, 32'd2);
        issue_request(OP_TICK, 8'h00, 16'h0000, 32'd5);
        issue_request(OP_TICK, 8'hFF, 16'hFFFF, 32'd6);
        issue_request(OP_TICK, 8'h00, 16'h0000, 32'd100);
        issue_request(OP_TIMED, 8'hA5, 16'hFFFF, 32'hFFFF_FFFF);
        issue_request(OP_TIMED, 8'h5A, 16'h0000, 32'hFFFF_0000);
        issue_request(OP_TICK, 8'h00, 16'h0000, 32'hFFFF_FFFF);
        issue_request(OP_TICK, 8'h00, 16'h0000, 32'hFFFF_FFFF);
        for (int k = 0; k <= TS; k++)
            issue_request(OP_TIMED, 8'(8'h10 + k), 16'(1000 + k), 32'd0);
        issue_request(OP_TICK, 8'h00, 16'h0000, 32'd0);
        issue_request(OP_TICK, 8'h00, 16'h0000, 32'd1004);
        clock_ms = 32'd1004;

        while (sb.requests < 425)
        begin
            idle_pct = (sb.requests >= 180 && sb.requests < 260) ? 0 : 16;
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    n = $urandom_range(1, 14);
                    repeat (n)
                        issue_request(OP_POST, 8'($urandom_range(0, 255)),
                                      16'($urandom_range(0, 65535)), clock_ms);
                end
                2, 3:
                begin
                    n = $urandom_range(1, 9);
                    repeat (n)
                        issue_request(OP_TIMED, 8'($urandom_range(0, 255)),
                                      16'($urandom_range(0, 60)), clock_ms);
                end
                4, 5, 6:
                begin
                    n = $urandom_range(1, 12);
                    repeat (n)
                        tick_request();
                end
                7:
                begin
                    fill_to_overflow();
                end
                8:
                begin
                    n = $urandom_range(1, 6);
                    repeat (n)
                        noise_request();
                end
                default:
                begin
                    if ($urandom_range(0, 3) == 0)
                        clock_ms = $urandom();
                    else
                        clock_ms += $urandom_range(0, 1 << 20);
                    tick_request();
                end
            endcase
        end
        idle_pct = 16;

        if (sb.fill() == QD - 1)
            tick_request();
        issue_request(OP_STOP, 8'hFF, 16'hFFFF, clock_ms);
        while (!sb.halted)
            tick_request();
        tick_request();
        issue_request(OP_POST, 8'h3C, 16'h1234, clock_ms);
        issue_request(OP_TIMED, 8'hC3, 16'h0000, clock_ms);
        issue_request(OP_STOP, 8'h00, 16'h0000, clock_ms);
        tick_request();
        in_valid <= 1'b0;

        while (sb.due_results.size() != 0)
            @(posedge clk);
        repeat (TS + 20) @(posedge clk);

        $display("Run covered %0d requests with %0d dispatches and %0d idle ticks,",
                 sb.requests, sb.dispatches, sb.idle_ticks);
        $display("%0d queue overflows, %0d full timer tables, ending in the stopped state.",
                 sb.overflows, sb.table_full);
        if (sb.errors == 0)
            $display("tb_cooperative_task_scheduler_unit: done, clean");
        else
            $display("tb_cooperative_task_scheduler_unit: done, errors");
        $finish;
    end

endmodule
